### hw/rtl/odd_even_transposition_sorter_macros.svh
// ----------------------------------------------------------------------------
// odd_even_transposition_sorter_macros
// assertion macros used by the checker file of the sorter
// ----------------------------------------------------------------------------
`ifndef ODD_EVEN_TRANSPOSITION_SORTER_MACROS_SVH
`define ODD_EVEN_TRANSPOSITION_SORTER_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define OETS_ASSERT_ON(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// same, with the usual clock and reset names
`define OETS_ASSERT(lbl, prop, msg) \
    `OETS_ASSERT_ON(lbl, clk, rst_n, prop, msg)

`endif

### hw/rtl/oets_pkg.sv
// ----------------------------------------------------------------------------
// oets_pkg
// shared types and constants of the odd-even transposition sorter
// ----------------------------------------------------------------------------
package oets_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 16;

    typedef logic signed [DATA_W-1:0] data_t;

endpackage

### hw/rtl/oets_in_if.sv
// ----------------------------------------------------------------------------
// oets_in_if
// input channel of the sorter: one value per word, last marks batch end
// ----------------------------------------------------------------------------
interface oets_in_if import oets_pkg::*; ();

    logic  valid;
    logic  ready;
    data_t value_in;
    logic  last_in;

    modport source (output valid, output value_in, output last_in, input ready);
    modport sink   (input valid, input value_in, input last_in, output ready);

endinterface

### hw/rtl/oets_out_if.sv
// ----------------------------------------------------------------------------
// oets_out_if
// output channel of the sorter: sorted values, last and overflow flag
// ----------------------------------------------------------------------------
interface oets_out_if import oets_pkg::*; ();

    logic  valid;
    logic  ready;
    data_t value_out;
    logic  last_out;
    logic  dropped;

    modport source (output valid, output value_out, output last_out, output dropped,
                    input ready);
    modport sink   (input valid, input value_out, input last_out, input dropped,
                    output ready);

endinterface

### hw/rtl/oets_bank.sv
// ----------------------------------------------------------------------------
// oets_bank
// one element bank: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module oets_bank import oets_pkg::*; #(
    parameter int DEPTH = MAX_ITEMS_DEF / 2,
    parameter int AW    = 3
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  data_t         wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output data_t         rdata
);

    data_t mem [DEPTH];
    data_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/odd_even_transposition_sorter.sv
// ----------------------------------------------------------------------------
// odd_even_transposition_sorter
// collects a batch of signed values, sorts it in two memory banks by
// odd-even transposition and streams the sorted batch out
// ----------------------------------------------------------------------------
// channel   dir  handshake      payload
// in_ch     in   valid/ready    value_in, last_in
// out_ch    out  valid/ready    value_out, last_out, dropped
//
// load: one word per cycle; ready is low while a batch is sorted or sent.
// sort: element 2j sits in the even bank, 2j+1 in the odd bank, so each
//   neighbor pair is one read and one write per bank; a batch of n takes
//   at most n + 2 phases.
// output: each word goes through a bank read, then the output register;
//   the next read waits for the pending one, and a stall holds the output register and the next read.
// reset clears all control state; bank contents are not cleared.
// ----------------------------------------------------------------------------
module odd_even_transposition_sorter import oets_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    oets_in_if.sink      in_ch,
    oets_out_if.source   out_ch
);

    localparam int BANK_DEPTH = (MAX_ITEMS + 1) / 2;
    localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int CW         = $clog2(MAX_ITEMS + 1);

    typedef enum logic [1:0] {
        S_LOAD,
        S_SORT,
        S_OUT
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            overflow_reg, overflow_next;
    logic            parity_reg, parity_next;
    logic [CW-1:0]   pair_reg, pair_next;
    logic            pend_reg, pend_next;
    logic [AW-1:0]   pend_even_addr_reg, pend_even_addr_next;
    logic [AW-1:0]   pend_odd_addr_reg, pend_odd_addr_next;
    logic            swap_now_reg, swap_now_next;
    logic            swap_prev_reg, swap_prev_next;
    logic [CW-1:0]   k_reg, k_next;
    logic            rd_pend_reg, rd_pend_next;
    logic            rd_sel_reg, rd_sel_next;
    logic            rd_last_reg, rd_last_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_last_reg, out_last_next;
    data_t           out_value_reg;

    logic            in_accept, out_accept, room;
    logic [CW-1:0]   npairs;
    logic            sort_issue, out_issue;
    logic [AW-1:0]   sort_even_addr, sort_odd_addr;
    data_t           even_rdata, odd_rdata, lo_val, hi_val, min_val, max_val;
    logic            swap;

    logic            even_we, odd_we, even_re, odd_re;
    logic [AW-1:0]   even_waddr, odd_waddr, even_raddr, odd_raddr;
    data_t           even_wdata, odd_wdata;

    assign in_ch.ready = (state_reg == S_LOAD);
    assign in_accept   = in_ch.valid && in_ch.ready;
    assign out_accept  = out_valid_reg && out_ch.ready;
    assign room        = (count_reg < CW'(MAX_ITEMS));

    // pairs in this phase: even phase n/2, odd phase (n-1)/2
    assign npairs     = parity_reg ? ((count_reg - CW'(1)) >> 1) : (count_reg >> 1);
    assign sort_issue = (state_reg == S_SORT) && (pair_reg < npairs);

    always_comb
    begin
        if (parity_reg)
        begin
            sort_odd_addr  = AW'(pair_reg);
            sort_even_addr = AW'(pair_reg + CW'(1));
        end
        else
        begin
            sort_odd_addr  = AW'(pair_reg);
            sort_even_addr = AW'(pair_reg);
        end
    end

    assign out_issue = (state_reg == S_OUT) && !rd_pend_reg && (k_reg < count_reg)
                       && (!out_valid_reg || out_ch.ready);

    // compare and swap on the word pair read last cycle
    assign lo_val  = parity_reg ? odd_rdata : even_rdata;
    assign hi_val  = parity_reg ? even_rdata : odd_rdata;
    assign swap    = lo_val > hi_val;
    assign min_val = swap ? hi_val : lo_val;
    assign max_val = swap ? lo_val : hi_val;

    // bank port muxing
    always_comb
    begin
        even_we    = 1'b0;
        odd_we     = 1'b0;
        even_waddr = AW'(count_reg >> 1);
        odd_waddr  = AW'(count_reg >> 1);
        even_wdata = in_ch.value_in;
        odd_wdata  = in_ch.value_in;
        if (state_reg == S_LOAD)
        begin
            even_we = in_accept && room && !count_reg[0];
            odd_we  = in_accept && room && count_reg[0];
        end
        else if (pend_reg)
        begin
            even_we    = 1'b1;
            odd_we     = 1'b1;
            even_waddr = pend_even_addr_reg;
            odd_waddr  = pend_odd_addr_reg;
            even_wdata = parity_reg ? max_val : min_val;
            odd_wdata  = parity_reg ? min_val : max_val;
        end
    end

    always_comb
    begin
        if (state_reg == S_OUT)
        begin
            even_re    = out_issue;
            odd_re     = out_issue;
            even_raddr = AW'(k_reg >> 1);
            odd_raddr  = AW'(k_reg >> 1);
        end
        else
        begin
            even_re    = sort_issue;
            odd_re     = sort_issue;
            even_raddr = sort_even_addr;
            odd_raddr  = sort_odd_addr;
        end
    end

    oets_bank #(
        .DEPTH (BANK_DEPTH),
        .AW    (AW)
    ) u_even_bank (
        .clk   (clk),
        .we    (even_we),
        .waddr (even_waddr),
        .wdata (even_wdata),
        .re    (even_re),
        .raddr (even_raddr),
        .rdata (even_rdata)
    );

    oets_bank #(
        .DEPTH (BANK_DEPTH),
        .AW    (AW)
    ) u_odd_bank (
        .clk   (clk),
        .we    (odd_we),
        .waddr (odd_waddr),
        .wdata (odd_wdata),
        .re    (odd_re),
        .raddr (odd_raddr),
        .rdata (odd_rdata)
    );

    always_comb
    begin
        state_next          = state_reg;
        count_next          = count_reg;
        overflow_next       = overflow_reg;
        parity_next         = parity_reg;
        pair_next           = pair_reg;
        pend_next           = 1'b0;
        pend_even_addr_next = sort_even_addr;
        pend_odd_addr_next  = sort_odd_addr;
        swap_now_next       = swap_now_reg;
        swap_prev_next      = swap_prev_reg;
        k_next              = k_reg;
        rd_pend_next        = out_issue;
        rd_sel_next         = k_reg[0];
        rd_last_next        = (k_reg + CW'(1)) == count_reg;
        out_valid_next      = out_valid_reg;
        out_last_next       = out_last_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_accept)
                begin
                    if (room)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (in_ch.last_in)
                    begin
                        state_next     = S_SORT;
                        parity_next    = 1'b0;
                        pair_next      = '0;
                        swap_prev_next = 1'b1;
                        swap_now_next  = 1'b0;
                    end
                end
            end
            S_SORT:
            begin
                if (pend_reg && swap)
                begin
                    swap_now_next = 1'b1;
                end
                if (sort_issue)
                begin
                    pend_next = 1'b1;
                    pair_next = pair_reg + CW'(1);
                end
                else if (!pend_reg)
                begin
                    // phase done and its last write has landed
                    if (!swap_prev_reg && !swap_now_reg)
                    begin
                        state_next = S_OUT;
                        k_next     = '0;
                    end
                    else
                    begin
                        swap_prev_next = swap_now_reg;
                        swap_now_next  = 1'b0;
                        parity_next    = !parity_reg;
                        pair_next      = '0;
                    end
                end
            end
            S_OUT:
            begin
                if (out_issue)
                begin
                    k_next = k_reg + CW'(1);
                end
                if (out_accept)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        state_next    = S_LOAD;
                        count_next    = '0;
                        overflow_next = 1'b0;
                        parity_next   = 1'b0;
                    end
                end
                if (rd_pend_reg)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = rd_last_reg;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            count_reg      <= '0;
            overflow_reg   <= 1'b0;
            parity_reg     <= 1'b0;
            pair_reg       <= '0;
            pend_reg       <= 1'b0;
            swap_now_reg   <= 1'b0;
            swap_prev_reg  <= 1'b0;
            k_reg          <= '0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            overflow_reg   <= overflow_next;
            parity_reg     <= parity_next;
            pair_reg       <= pair_next;
            pend_reg       <= pend_next;
            swap_now_reg   <= swap_now_next;
            swap_prev_reg  <= swap_prev_next;
            k_reg          <= k_next;
            rd_pend_reg    <= rd_pend_next;
            out_valid_reg  <= out_valid_next;
            out_last_reg   <= out_last_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_even_addr_reg <= pend_even_addr_next;
        pend_odd_addr_reg  <= pend_odd_addr_next;
        rd_sel_reg         <= rd_sel_next;
        rd_last_reg        <= rd_last_next;
        if (rd_pend_reg)
        begin
            out_value_reg <= rd_sel_reg ? odd_rdata : even_rdata;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.value_out = out_value_reg;
    assign out_ch.last_out  = out_last_reg;
    assign out_ch.dropped   = overflow_reg;

endmodule

### hw/rtl/oets_checker.sv
// ----------------------------------------------------------------------------
// oets_checker
// port-level checks of the sorter, bound to the top level
// ----------------------------------------------------------------------------
`include "odd_even_transposition_sorter_macros.svh"

module oets_checker import oets_pkg::*; (
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_ready,
    input logic  in_last,
    input logic  out_valid,
    input logic  out_ready,
    input data_t out_value,
    input logic  out_last
);

    `OETS_ASSERT(a_out_valid_held, out_valid && !out_ready |=> out_valid, "stalled word lost")
    `OETS_ASSERT(a_out_value_held, out_valid && !out_ready |=> $stable(out_value), "stalled word changed")
    // no loading while a sorted batch is still going out
    `OETS_ASSERT(a_no_load_in_output, out_valid |-> !in_ready, "input taken during output")
    // a batch end closes the input until the batch has been sent
    `OETS_ASSERT(a_closed_after_last, in_valid && in_ready && in_last |=> !in_ready, "input open after batch end")
    // the final word of a batch reopens the input next cycle
    `OETS_ASSERT(a_open_after_batch, out_valid && out_ready && out_last |=> in_ready, "input not reopened")

endmodule

bind odd_even_transposition_sorter oets_checker u_oets_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_last   (in_ch.last_in),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_value (out_ch.value_out),
    .out_last  (out_ch.last_out)
);
